>>> hdl/sso_pkg.sv
// Shared constants for the searchlight shadow overlay.
package sso_pkg;

  localparam logic [1:0] OP_PIXEL = 2'd0;
  localparam logic [1:0] OP_MAP   = 2'd1;
  localparam logic [1:0] OP_GLYPH = 2'd2;

  localparam logic REG_IMAGE  = 1'b0;
  localparam logic REG_ENABLE = 1'b1;

  localparam logic [8:0] SCREEN_WIDTH  = 9'd256;
  localparam logic [8:0] SCREEN_HEIGHT = 9'd224;

  localparam int MAP_DEPTH   = 4096;
  localparam int GLYPH_DEPTH = 512;
  localparam int MAP_AW      = 12;
  localparam int GLYPH_AW    = 9;

  localparam logic [5:0] FORCED_CODE = 6'd1;

endpackage

>>> hdl/sso_ram.sv
// Generic simple dual-port RAM with registered read.
module sso_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/searchlight_shadow_overlay.sv
// Searchlight shadow overlay top level: light map lookup, glyph lookup, output register.
// Path from input word accept to output word valid: map read, glyph read, output reg.
// Throughput: one word per cycle unless the output stalls; one map and one glyph read per word.
// Map bytes are written at accept; glyph rows are written in the glyph-read stage, in word order.
// Reset clears valid bits and config registers (image_select = 0, overlay_enable = 0).
// RAM contents are not cleared; no clearing pass, the block is ready right after reset.
module searchlight_shadow_overlay (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // load_address[11:0], load_data[19:12], pixel_x[27:20], pixel_y[35:28], pixel_in[43:36]
  input  logic [47:0] s_axis_tdata_i,
  // opcode[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // pixel_out[8:0]
  output logic [15:0] m_axis_tdata_o,
  // shaded[0]
  output logic        m_axis_tuser_o
);

  // config registers
  logic [3:0] image_q;
  logic       enable_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_q  <= 4'd0;
      enable_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sso_pkg::REG_IMAGE:  image_q  <= cfg_data_i;
        sso_pkg::REG_ENABLE: enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input unpack
  logic [1:0]  in_op;
  logic [11:0] in_addr;
  logic [7:0]  in_data;
  logic [7:0]  in_x;
  logic [7:0]  in_y;
  logic [7:0]  in_pix;

  assign in_op   = s_axis_tuser_i;
  assign in_addr = s_axis_tdata_i[11:0];
  assign in_data = s_axis_tdata_i[19:12];
  assign in_x    = s_axis_tdata_i[27:20];
  assign in_y    = s_axis_tdata_i[35:28];
  assign in_pix  = s_axis_tdata_i[43:36];

  // handshake chain
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic s1_ready, s2_ready, s1_fire, s2_fire, in_fire;

  assign s2_ready        = !out_valid_q || m_axis_tready_i;
  assign s1_ready        = !s2_valid_q || s2_ready;
  assign s_axis_tready_o = !s1_valid_q || s1_ready;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign s1_fire         = s1_valid_q && s1_ready;
  assign s2_fire         = s2_valid_q && s2_ready;

  // stage 0: map address and map RAM access
  logic                       cell_mirror;
  logic                       on_screen;
  logic [sso_pkg::MAP_AW-1:0] map_raddr;
  logic [7:0]                 map_rdata;

  assign cell_mirror = in_x[7];
  assign on_screen   = ({1'b0, in_x} < sso_pkg::SCREEN_WIDTH) &&
                       ({1'b0, in_y} < sso_pkg::SCREEN_HEIGHT);
  assign map_raddr   = {image_q[2:0], in_y[7:3], in_x[6:3] ^ {4{cell_mirror}}};

  sso_ram #(
    .WIDTH (8),
    .DEPTH (sso_pkg::MAP_DEPTH)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && (in_op == sso_pkg::OP_MAP)),
    .waddr_i (in_addr),
    .wdata_i (in_data),
    .re_i    (in_fire && (in_op == sso_pkg::OP_PIXEL)),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  // stage 1 registers
  logic [1:0]                   s1_op_q;
  logic [sso_pkg::GLYPH_AW-1:0] s1_addr_q;
  logic [7:0]                   s1_data_q;
  logic [2:0]                   s1_yrow_q;
  logic [2:0]                   s1_px_q;
  logic                         s1_flip_q;
  logic                         s1_active_q;
  logic [7:0]                   s1_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= (in_op == sso_pkg::OP_PIXEL) || (in_op == sso_pkg::OP_GLYPH);
    end else if (s1_ready) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q     <= in_op;
      s1_addr_q   <= in_addr[sso_pkg::GLYPH_AW-1:0];
      s1_data_q   <= in_data;
      s1_yrow_q   <= in_y[2:0];
      s1_px_q     <= in_x[2:0] ^ {3{cell_mirror}};
      s1_flip_q   <= cell_mirror != image_q[3];
      s1_active_q <= enable_q && on_screen;
      s1_pix_q    <= in_pix;
    end
  end

  // stage 1: tile code and glyph RAM access
  logic [5:0]                   tile_code;
  logic [sso_pkg::GLYPH_AW-1:0] glyph_raddr;
  logic [7:0]                   glyph_rdata;

  assign tile_code   = (s1_flip_q && map_rdata[7]) ? sso_pkg::FORCED_CODE : map_rdata[5:0];
  assign glyph_raddr = {tile_code, s1_yrow_q};

  sso_ram #(
    .WIDTH (8),
    .DEPTH (sso_pkg::GLYPH_DEPTH)
  ) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire && (s1_op_q == sso_pkg::OP_GLYPH)),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_data_q),
    .re_i    (s1_fire && (s1_op_q == sso_pkg::OP_PIXEL)),
    .raddr_i (glyph_raddr),
    .rdata_o (glyph_rdata)
  );

  // stage 2 registers
  logic [2:0] s2_px_q;
  logic       s2_active_q;
  logic [7:0] s2_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_fire) begin
      s2_valid_q <= (s1_op_q == sso_pkg::OP_PIXEL);
    end else if (s2_ready) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      s2_px_q     <= s1_px_q;
      s2_active_q <= s1_active_q;
      s2_pix_q    <= s1_pix_q;
    end
  end

  // stage 2: glyph bit select, output register
  logic       hit;
  logic [8:0] pix_out_q;
  logic       shaded_q;

  assign hit = s2_active_q && glyph_rdata[s2_px_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      pix_out_q <= {hit, s2_pix_q};
      shaded_q  <= hit;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, pix_out_q};
  assign m_axis_tuser_o  = shaded_q;

  // checks
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && (s1_op_q != sso_pkg::OP_PIXEL)) |=> !s2_valid_q)
    else $error("load word produced a result");

  a_shade_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (pix_out_q[8] == shaded_q))
    else $error("shadow palette bit disagrees with shaded flag");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_ready) |=> (s1_valid_q && $stable(s1_op_q) && $stable(s1_pix_q)))
    else $error("stage 1 word lost during stall");

  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !s2_ready) |=> (s2_valid_q && $stable(s2_pix_q) && $stable(glyph_rdata)))
    else $error("stage 2 word lost during stall");

endmodule
